// ===== hw/rtl/scps_pkg.sv =====
`default_nettype none

package scps_pkg;

   localparam int UNITS_W = 5;
   localparam int TICKS_W = 12;
   localparam int COUNT_W = 7;
   localparam int TPU_W   = 7;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   // ticks per configured unit, pulse phases and gap phases
   localparam logic [TPU_W-1:0] TICKS_PER_PULSE_UNIT = 7'd25;
   localparam logic [TPU_W-1:0] TICKS_PER_GAP_UNIT   = 7'd125;

   localparam logic [UNITS_W-1:0] UNITS_RESET = 5'd2;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_ADV  = 3'd1,
      PH_GAP1 = 3'd2,
      PH_SHUT = 3'd3,
      PH_GAP2 = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      REG_ADV_UNITS  = 2'd0,
      REG_GAP1_UNITS = 2'd1,
      REG_SHUT_UNITS = 2'd2,
      REG_GAP2_UNITS = 2'd3
   } reg_index_type;

   // first phase of a slide with a nonzero length, idle if all are zero
   function automatic phase_type first_phase(input logic [3:0] nz);
      phase_type p;
      if (nz[0])      p = PH_ADV;
      else if (nz[1]) p = PH_GAP1;
      else if (nz[2]) p = PH_SHUT;
      else if (nz[3]) p = PH_GAP2;
      else            p = PH_IDLE;
      return p;
   endfunction

   // next nonzero phase after cur within the same slide, idle at slide end
   function automatic phase_type next_phase(input phase_type cur, input logic [3:0] nz);
      phase_type p;
      p = PH_IDLE;
      case (cur)
         PH_ADV: begin
            if (nz[1])      p = PH_GAP1;
            else if (nz[2]) p = PH_SHUT;
            else if (nz[3]) p = PH_GAP2;
         end
         PH_GAP1: begin
            if (nz[2])      p = PH_SHUT;
            else if (nz[3]) p = PH_GAP2;
         end
         PH_SHUT: begin
            if (nz[3])      p = PH_GAP2;
         end
         default: p = PH_IDLE;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/slide_copy_pulse_sequencer_core.sv =====
`default_nettype none

// channel   direction  beat contents
// req       in         tdata[6:0] slide_count, tuser[0] operation (0 tick, 1 start)
// rsp       out        tdata[2:0] advance/shutter/idle, tlast run_finished
// csr       in/out     apb registers 0..3 at byte offsets 0x0, 0x4, 0x8, 0xc
//
// one beat per cycle while req_tready is high: each req beat updates the sequencer state
// and its result lands in the rsp output register at the edge it is accepted
// req_tready drops only while a result sits unclaimed in the output register
// reset (synchronous) puts the sequencer idle and all unit registers at 2
// a phase length is sampled from its unit register when the phase is entered

module slide_copy_pulse_sequencer_core (
   input  wire                          clock,
   input  wire                          reset,
   // req beat
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [7:0]                   req_tdata,   // [6:0] slide_count
   input  wire  [0:0]                   req_tuser,   // [0] operation
   // rsp beat
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [0] advance, [1] shutter, [2] idle
   output logic                         rsp_tlast,   // run_finished
   // configuration
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [scps_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire  [scps_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [scps_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import scps_pkg::*;

   // unit registers
   logic [UNITS_W-1:0] adv_units_ff, gap1_units_ff, shut_units_ff, gap2_units_ff;
   reg_index_type      csr_index;
   logic               csr_write;

   // sequencer state
   phase_type          phase_ff, phase_in;
   logic [TICKS_W-1:0] ticks_ff, ticks_in;
   logic [COUNT_W-1:0] slides_ff, slides_in;
   logic               pending_ff, pending_in;
   logic [COUNT_W-1:0] pcount_ff, pcount_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_flags_ff, rsp_flags_in;
   logic               rsp_fin_ff, rsp_fin_in;

   logic               req_accept;
   logic               op_start;
   logic [COUNT_W-1:0] req_count;
   logic [3:0]         nz;
   phase_type          first_ph, after_ph, load_ph;
   logic               load_en;
   logic               fin;
   logic [COUNT_W-1:0] slides_dec;
   logic [UNITS_W-1:0] load_units;
   logic [TPU_W-1:0]   load_tpu;
   logic [TICKS_W-1:0] load_len;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         adv_units_ff  <= UNITS_RESET;
         gap1_units_ff <= UNITS_RESET;
         shut_units_ff <= UNITS_RESET;
         gap2_units_ff <= UNITS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_ADV_UNITS:  adv_units_ff  <= csr_pwdata[UNITS_W-1:0];
            REG_GAP1_UNITS: gap1_units_ff <= csr_pwdata[UNITS_W-1:0];
            REG_SHUT_UNITS: shut_units_ff <= csr_pwdata[UNITS_W-1:0];
            REG_GAP2_UNITS: gap2_units_ff <= csr_pwdata[UNITS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ADV_UNITS:  csr_prdata = DATA_W'(adv_units_ff);
         REG_GAP1_UNITS: csr_prdata = DATA_W'(gap1_units_ff);
         REG_SHUT_UNITS: csr_prdata = DATA_W'(shut_units_ff);
         REG_GAP2_UNITS: csr_prdata = DATA_W'(gap2_units_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- handshake
   // output register frees up in the same cycle its beat is taken
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign op_start   = req_tuser[0];
   assign req_count  = req_tdata[COUNT_W-1:0];

   // ---------------------------------------------------------------- step logic
   // zero-length phases are skipped, so only the nonzero map matters for order
   assign nz = {gap2_units_ff != '0, shut_units_ff != '0,
                gap1_units_ff != '0, adv_units_ff != '0};
   assign first_ph   = first_phase(nz);
   assign after_ph   = next_phase(phase_ff, nz);
   assign slides_dec = slides_ff - COUNT_W'(1);

   always_comb begin
      phase_in   = phase_ff;
      ticks_in   = ticks_ff;
      slides_in  = slides_ff;
      pending_in = pending_ff;
      pcount_in  = pcount_ff;
      load_en    = 1'b0;
      load_ph    = first_ph;
      fin        = 1'b0;

      if (req_accept) begin
         if (op_start) begin
            if (phase_ff == PH_IDLE) begin
               slides_in = req_count;
               ticks_in  = '0;
               // empty count or all-zero lengths finish at once
               if (req_count == '0 || first_ph == PH_IDLE) begin
                  fin = 1'b1;
               end else begin
                  load_en = 1'b1;
               end
            end else begin
               // start during a run: hold it, latest count wins
               pending_in = 1'b1;
               pcount_in  = req_count;
            end
         end else if (phase_ff != PH_IDLE) begin
            if (ticks_ff > TICKS_W'(1)) begin
               ticks_in = ticks_ff - TICKS_W'(1);
            end else if (after_ph != PH_IDLE) begin
               load_en = 1'b1;
               load_ph = after_ph;
            end else begin
               // slide done
               slides_in = slides_dec;
               if (slides_dec != '0 && first_ph != PH_IDLE) begin
                  load_en = 1'b1;
               end else begin
                  fin      = 1'b1;
                  phase_in = PH_IDLE;
                  ticks_in = '0;
                  if (pending_ff) begin
                     // pending run takes over in the same step
                     pending_in = 1'b0;
                     slides_in  = pcount_ff;
                     if (pcount_ff != '0 && first_ph != PH_IDLE) begin
                        load_en = 1'b1;
                     end
                  end
               end
            end
         end
      end

      if (load_en) begin
         phase_in = load_ph;
         ticks_in = load_len;
      end
   end

   // one small multiplier for the length of the phase being entered
   always_comb begin
      case (load_ph)
         PH_ADV: begin
            load_units = adv_units_ff;
            load_tpu   = TICKS_PER_PULSE_UNIT;
         end
         PH_GAP1: begin
            load_units = gap1_units_ff;
            load_tpu   = TICKS_PER_GAP_UNIT;
         end
         PH_SHUT: begin
            load_units = shut_units_ff;
            load_tpu   = TICKS_PER_PULSE_UNIT;
         end
         PH_GAP2: begin
            load_units = gap2_units_ff;
            load_tpu   = TICKS_PER_GAP_UNIT;
         end
         default: begin
            load_units = '0;
            load_tpu   = '0;
         end
      endcase
   end

   assign load_len = TICKS_W'(TICKS_W'(load_units) * TICKS_W'(load_tpu));

   // ---------------------------------------------------------------- result
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_flags_in = rsp_flags_ff;
      rsp_fin_in   = rsp_fin_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_flags_in = {phase_in == PH_IDLE, phase_in == PH_SHUT, phase_in == PH_ADV};
         rsp_fin_in   = fin;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         ticks_ff     <= '0;
         slides_ff    <= '0;
         pending_ff   <= 1'b0;
         pcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         ticks_ff     <= ticks_in;
         slides_ff    <= slides_in;
         pending_ff   <= pending_in;
         pcount_ff    <= pcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_flags_ff <= rsp_flags_in;
      rsp_fin_ff   <= rsp_fin_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_flags_ff};
   assign rsp_tlast  = rsp_fin_ff;

   // ---------------------------------------------------------------- checks
   // an active phase always has time left on it
   a_ticks_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> ticks_ff != '0)
      else $error("active phase with no ticks left");

   // an active run always has a slide to work on
   a_slides_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> slides_ff != '0)
      else $error("active phase with no slides left");

   // a held start only exists while a run is going
   a_pending_in_run: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> phase_ff != PH_IDLE)
      else $error("pending start while idle");

   // the idle lamp never shows together with a drive line
   a_idle_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flags_ff[2] |-> rsp_flags_ff[1:0] == 2'b00)
      else $error("idle lamp with a drive line active");

endmodule

`default_nettype wire

// ===== test/scps_sequence_checker.sv =====
`default_nettype none

module scps_sequence_checker
   import scps_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   input  wire                 req_tready,
   input  wire  [7:0]          req_tdata,   // [6:0] slide_count
   input  wire  [0:0]          req_tuser,   // [0] operation
   input  wire                 rsp_tvalid,
   input  wire                 rsp_tready,
   input  wire  [7:0]          rsp_tdata,   // [0] advance, [1] shutter, [2] idle
   input  wire                 rsp_tlast,   // run_finished
   input  wire                 csr_psel,
   input  wire                 csr_penable,
   input  wire                 csr_pwrite,
   input  wire  [ADDR_W-1:0]   csr_paddr,
   input  wire  [DATA_W-1:0]   csr_pwdata,
   input  wire  [DATA_W-1:0]   csr_prdata,
   input  wire                 csr_pready,
   output int                  fail_count,
   output int                  outstanding,
   output logic                seq_idle,
   output int                  results_checked,
   output int                  runs_ended
);

   typedef struct packed {
      logic advance;
      logic shutter;
      logic idle;
      logic finished;
   } drive_lines_type;

   logic [UNITS_W-1:0] unit_reg [4];
   phase_type          cur_phase    = PH_IDLE;
   logic [TICKS_W-1:0] ticks_rem    = '0;
   logic [COUNT_W-1:0] slides_rem   = '0;
   logic               queued_start = 1'b0;
   logic [COUNT_W-1:0] queued_count = '0;

   drive_lines_type expected_lines [$];
   int n_fail    = 0;
   int n_checked = 0;
   int n_runs    = 0;

   initial begin
      fail_count      = 0;
      outstanding     = 0;
      seq_idle        = 1'b1;
      results_checked = 0;
      runs_ended      = 0;
      foreach (unit_reg[i]) unit_reg[i] = UNITS_RESET;
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (n_fail < 40)
         $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
      n_fail++;
   endtask

   // phase length is taken from its unit register on entry
   function automatic void enter_phase(input phase_type p);
      int len;
      case (p)
         PH_ADV:  len = unit_reg[REG_ADV_UNITS] * TICKS_PER_PULSE_UNIT;
         PH_GAP1: len = unit_reg[REG_GAP1_UNITS] * TICKS_PER_GAP_UNIT;
         PH_SHUT: len = unit_reg[REG_SHUT_UNITS] * TICKS_PER_PULSE_UNIT;
         PH_GAP2: len = unit_reg[REG_GAP2_UNITS] * TICKS_PER_GAP_UNIT;
         default: len = 0;
      endcase
      cur_phase = p;
      ticks_rem = len[TICKS_W-1:0];
   endfunction

   // walk through expired phases, returns 1 when a run ended on the way
   function automatic logic drain_expired_phases();
      logic ended;
      ended = 1'b0;
      while (cur_phase != PH_IDLE && ticks_rem == 0) begin
         if (cur_phase != PH_GAP2) begin
            enter_phase(phase_type'(cur_phase + 1));
         end else begin
            slides_rem = slides_rem - 1'b1;
            if (slides_rem != 0) begin
               enter_phase(PH_ADV);
            end else begin
               ended     = 1'b1;
               cur_phase = PH_IDLE;
               ticks_rem = '0;
               if (queued_start) begin
                  queued_start = 1'b0;
                  slides_rem   = queued_count;
                  if (slides_rem != 0) enter_phase(PH_ADV);
               end
            end
         end
      end
      return ended;
   endfunction

   function automatic drive_lines_type sequence_step(input logic is_start,
                                                     input logic [COUNT_W-1:0] count);
      drive_lines_type lines;
      logic ended;
      ended = 1'b0;
      if (is_start) begin
         if (cur_phase == PH_IDLE) begin
            slides_rem = count;
            ticks_rem  = '0;
            if (count == 0) begin
               ended = 1'b1;
            end else begin
               enter_phase(PH_ADV);
               ended = drain_expired_phases();
            end
         end else begin
            queued_start = 1'b1;
            queued_count = count;
         end
      end else if (cur_phase != PH_IDLE) begin
         if (ticks_rem != 0) ticks_rem = ticks_rem - 1'b1;
         ended = drain_expired_phases();
      end
      lines.advance  = (cur_phase == PH_ADV);
      lines.shutter  = (cur_phase == PH_SHUT);
      lines.idle     = (cur_phase == PH_IDLE);
      lines.finished = ended;
      return lines;
   endfunction

   always @(posedge clock) begin
      drive_lines_type want;
      reg_index_type idx;
      if (reset) begin
         foreach (unit_reg[i]) unit_reg[i] = UNITS_RESET;
         cur_phase    = PH_IDLE;
         ticks_rem    = '0;
         slides_rem   = '0;
         queued_start = 1'b0;
         queued_count = '0;
         expected_lines.delete();
      end else begin
         // the oldest expectation goes first, a new beat can only add a newer one
         if (rsp_tvalid && rsp_tready) begin
            if (expected_lines.size() == 0) begin
               report_mismatch("result with nothing pending", 0,
                               {23'b0, rsp_tlast, rsp_tdata});
            end else begin
               want = expected_lines.pop_front();
               if (rsp_tdata[0] !== want.advance)
                  report_mismatch("advance_drive", want.advance, rsp_tdata[0]);
               if (rsp_tdata[1] !== want.shutter)
                  report_mismatch("shutter_drive", want.shutter, rsp_tdata[1]);
               if (rsp_tdata[2] !== want.idle)
                  report_mismatch("idle_lamp", want.idle, rsp_tdata[2]);
               if (rsp_tlast !== want.finished)
                  report_mismatch("run_finished", want.finished, rsp_tlast);
               if (rsp_tdata[7:3] !== 5'b0)
                  report_mismatch("rsp_tdata padding", 0, rsp_tdata[7:3]);
               if (want.finished) n_runs++;
               n_checked++;
            end
         end
         if (csr_psel && csr_penable && csr_pready) begin
            idx = reg_index_type'(csr_paddr[3:2]);
            if (csr_pwrite)
               unit_reg[idx] = csr_pwdata[UNITS_W-1:0];
            else if (csr_prdata !== {{(DATA_W-UNITS_W){1'b0}}, unit_reg[idx]})
               report_mismatch("register readback", unit_reg[idx], csr_prdata);
         end
         if (req_tvalid && req_tready)
            expected_lines.push_back(sequence_step(req_tuser[0], req_tdata[COUNT_W-1:0]));
      end
      fail_count      <= n_fail;
      outstanding     <= expected_lines.size();
      seq_idle        <= (cur_phase == PH_IDLE);
      results_checked <= n_checked;
      runs_ended      <= n_runs;
   end

endmodule

`default_nettype wire

// ===== test/slide_copy_pulse_sequencer_core_tb.sv =====
`default_nettype none

module slide_copy_pulse_sequencer_core_tb;
   import scps_pkg::*;

   // request kinds carried in req_tuser
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // cycles with no accepted beat before the run is declared hung
   localparam int WATCHDOG_LIMIT   = 1000;
   // long receiver hold-off, far longer than the block can buffer
   localparam int LONG_HOLD_CYCLES = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_tvalid = 1'b0;
   wire               req_tready;
   logic [7:0]        req_tdata  = '0;   // [6:0] slide_count
   logic [0:0]        req_tuser  = '0;   // [0] operation
   wire               rsp_tvalid;
   logic              rsp_tready = 1'b0;
   wire  [7:0]        rsp_tdata;         // [0] advance, [1] shutter, [2] idle
   wire               rsp_tlast;         // run_finished
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0] csr_paddr   = '0;
   logic [DATA_W-1:0] csr_pwdata  = '0;
   wire  [DATA_W-1:0] csr_prdata;
   wire               csr_pready;

   int   fail_count;
   int   outstanding;
   logic seq_idle;
   int   results_checked;
   int   runs_ended;

   // shared among the sender, receiver and watchdog processes
   bit gaps_on       = 1'b1;
   bit long_hold_req = 1'b0;
   int beats_sent    = 0;
   int settings_used = 0;
   int stuck_cycles  = 0;

   slide_copy_pulse_sequencer_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // watches both channels and the register port, predicts and compares
   scps_sequence_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .seq_idle        (seq_idle),
      .results_checked (results_checked),
      .runs_ended      (runs_ended)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // synchronous reset, held from the start and never raised again
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // watchdog: any accepted beat or register access counts as progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("slide_copy_pulse_sequencer_core test failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // result side: random stall bursts plus an occasional long hold-off,
   // exactly one nonblocking write of rsp_tready per edge
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD_CYCLES - 1;
            rsp_tready   <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            hold_left   = $urandom_range(0, 14);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // one request beat; returns at the edge where it was accepted with
   // tvalid still high so a following beat can go back to back
   task automatic send_beat(input logic op, input logic [COUNT_W-1:0] count);
      int gap;
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, count};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   // pause the sender until every expected result has been seen; the first
   // edge lets the checker count the beat accepted on the current edge
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // apb transfer: setup cycle, then access until pready; upper write bits are
   // random since only the low unit bits are stored
   task automatic csr_access(input logic wr, input reg_index_type idx,
                             input logic [UNITS_W-1:0] units);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {27'($urandom), units};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // new unit setting, only with nothing in flight; the sequencer itself may
   // still be mid-run, which exercises the sample-on-phase-entry behavior
   task automatic apply_units(input logic [UNITS_W-1:0] adv, input logic [UNITS_W-1:0] gap1,
                              input logic [UNITS_W-1:0] shut, input logic [UNITS_W-1:0] gap2);
      wait_drained();
      csr_access(1'b1, REG_ADV_UNITS, adv);
      csr_access(1'b1, REG_GAP1_UNITS, gap1);
      csr_access(1'b1, REG_SHUT_UNITS, shut);
      csr_access(1'b1, REG_GAP2_UNITS, gap2);
      csr_access(1'b0, REG_ADV_UNITS, '0);
      csr_access(1'b0, REG_GAP1_UNITS, '0);
      csr_access(1'b0, REG_SHUT_UNITS, '0);
      csr_access(1'b0, REG_GAP2_UNITS, '0);
      settings_used++;
   endtask

   // mostly ticks so runs actually complete; starts are frequent while the
   // sequencer is idle and rarer during a run, where they become pending
   task automatic random_beats(input int n);
      int sel;
      logic [COUNT_W-1:0] count;
      repeat (n) begin
         sel = $urandom_range(0, 9);
         case (sel)
            0:       count = '0;
            1, 2, 3,
            4:       count = 7'd1;
            5, 6:    count = 7'd2;
            7:       count = 7'd3;
            8:       count = COUNT_W'($urandom_range(0, 127));
            default: count = COUNT_W'($urandom_range(4, 12));
         endcase
         if (seq_idle ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 40) == 0))
            send_beat(OP_START, count);
         else
            send_beat(OP_TICK, COUNT_W'($urandom));
      end
   endtask

   initial begin
      while (reset) @(posedge clock);

      // directed: tick while idle and a zero-slide start at reset lengths
      send_beat(OP_TICK, 7'h55);
      send_beat(OP_START, 7'd0);
      // all lengths zero: the largest count finishes in the step it starts
      apply_units(5'd0, 5'd0, 5'd0, 5'd0);
      send_beat(OP_START, 7'd127);
      // one advance unit only: start, two starts during the run (the second
      // overwrites the pending count), then ticks to the end of the slide
      // where the pending run takes over in the same step
      apply_units(5'd1, 5'd0, 5'd0, 5'd0);
      send_beat(OP_START, 7'd1);
      send_beat(OP_START, 7'd3);
      send_beat(OP_START, 7'd2);
      repeat (25) send_beat(OP_TICK, COUNT_W'($urandom));

      // random phases over a range of unit settings
      apply_units(5'd0, 5'd0, 5'd0, 5'd0);
      random_beats(110);
      apply_units(5'd1, 5'd0, 5'd1, 5'd0);
      random_beats(130);
      // receiver holds off while the sender keeps offering, so the block stalls
      apply_units(5'd0, 5'd1, 5'd0, 5'd0);
      long_hold_req = 1'b1;
      random_beats(120);
      // largest lengths
      apply_units(5'd31, 5'd31, 5'd31, 5'd31);
      random_beats(80);
      apply_units(5'd2, 5'd0, 5'd0, 5'd1);
      random_beats(120);
      apply_units(5'd0, 5'd0, 5'd1, 5'd0);
      random_beats(120);
      apply_units(5'd1, 5'd0, 5'd0, 5'd0);
      random_beats(60);
      long_hold_req = 1'b1;
      random_beats(60);
      // closing stretch without any idling on either side
      gaps_on = 1'b0;
      apply_units(5'd1, 5'd1, 5'd0, 5'd0);
      random_beats(220);

      wait_drained();
      repeat (8) @(posedge clock);

      $display("summary: %0d request beats under %0d unit settings, %0d results checked",
               beats_sent, settings_used, results_checked);
      $display("summary: %0d runs ended, long result stalls and drained pauses included",
               runs_ended);
      if (fail_count == 0) begin
         $display("slide_copy_pulse_sequencer_core test passed");
      end else begin
         $display("slide_copy_pulse_sequencer_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/scps_pkg.sv
hw/rtl/slide_copy_pulse_sequencer_core.sv
test/scps_sequence_checker.sv
test/slide_copy_pulse_sequencer_core_tb.sv
